### rtl/core/dda_pkg.sv
// ----------------------------------------------------------------------------
// dda_pkg
// shared types and codes for the dual at dma controller core
// ----------------------------------------------------------------------------
package dda_pkg;

	localparam int unsigned InWidth  = 32;
	localparam int unsigned OutWidth = 56;

	typedef enum logic [1:0] {
		OP_PORT_RD  = 2'd0,
		OP_PORT_WR  = 2'd1,
		OP_SVC_MRD  = 2'd2,
		OP_SVC_MWR  = 2'd3
	} op_t;

	typedef enum logic [0:0] {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} state_t;

	// controller register slots
	localparam logic [3:0] REG_CMD_STAT  = 4'h8;
	localparam logic [3:0] REG_SMASK     = 4'hA;
	localparam logic [3:0] REG_MODE      = 4'hB;
	localparam logic [3:0] REG_CLR_FF    = 4'hC;
	localparam logic [3:0] REG_MCLR      = 4'hD;
	localparam logic [3:0] REG_CLR_MASK  = 4'hE;
	localparam logic [3:0] REG_MASK_ALL  = 4'hF;

	// per channel record held in the channel memory
	typedef struct packed {
		logic [23:0] base_addr;
		logic [23:0] cur_addr;
		logic [15:0] base_cnt;
		logic [16:0] cur_cnt;
		logic [7:0]  mode;
	} chan_rec_t;

endpackage

### rtl/core/dda_chan_mem.sv
// ----------------------------------------------------------------------------
// dda_chan_mem
// eight entry channel record memory, one write and one registered read port
// ----------------------------------------------------------------------------
module dda_chan_mem (
	input  logic                  clk,
	input  logic                  rd_en,
	input  logic [2:0]            rd_addr,
	output dda_pkg::chan_rec_t    rd_data,
	input  logic                  wr_en,
	input  logic [2:0]            wr_addr,
	input  dda_pkg::chan_rec_t    wr_data
);

	dda_pkg::chan_rec_t mem [8];
	dda_pkg::chan_rec_t rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

### rtl/core/dual_dma_controller_at_core.sv
// ----------------------------------------------------------------------------
// dual_dma_controller_at_core
// eight channel at dma controller: two cascaded 8237 style controllers
// ----------------------------------------------------------------------------
// Each beat passes through the idle and execute states: the channel record is
// read from the channel memory in the cycle the beat is accepted, and the
// execute state modifies it, writes it back and loads the result register,
// after which a new beat is taken; the registered read sets this order.
// An eight-bit valid mask, cleared by reset, makes a channel record that has
// not yet been written back read as all zero, so every channel starts from the
// reset state. The result register holds one finished beat, so a new beat may
// enter while it waits; that beat then holds in the execute state until the
// waiting result is taken.
// ----------------------------------------------------------------------------
module dual_dma_controller_at_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	// opcode[1:0], port_addr[9:2], data_in[25:10], channel[28:26], zero fill
	input  logic [31:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// read_data[7:0], mem_valid[8], mem_write[9], mem_word[10], mem_addr[34:11],
	// mem_wdata[50:35], no_data[51], terminal_count[52] (writes: mask), zero fill
	output logic [55:0] m_tdata
);

	dda_pkg::state_t state_q, state_d;

	logic        at_mode_q;
	logic [7:0]  mask_q, mask_d;
	logic [7:0]  tc_q, tc_d;
	logic [7:0]  cmd_q, cmd_d;
	logic [1:0]  ff_q, ff_d;
	logic [7:0]  lw_q [2][16];
	logic [7:0]  page_q [16];
	logic        lw_we;
	logic        page_we;
	logic [7:0]  vld_q;

	logic [1:0]  op_q;
	logic [7:0]  port_q;
	logic [15:0] data_q;
	logic [2:0]  ch_q;

	logic        m_valid_q;
	logic [55:0] m_data_q;
	logic [55:0] res;

	logic        accept, exec_fire;
	logic [2:0]  sel_ch;

	dda_pkg::chan_rec_t rec, nrec;
	dda_pkg::chan_rec_t rec_mem;

	// input fields
	logic [1:0]  in_op;
	logic [7:0]  in_port;
	logic [15:0] in_data;
	logic [2:0]  in_ch;

	assign in_op   = s_tdata[1:0];
	assign in_port = s_tdata[9:2];
	assign in_data = s_tdata[25:10];
	assign in_ch   = s_tdata[28:26];

	assign s_tready  = (state_q == dda_pkg::ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign exec_fire = (state_q == dda_pkg::ST_EXEC) && (!m_valid_q || m_tready);
	assign m_tvalid  = m_valid_q;
	assign m_tdata   = m_data_q;

	// which channel record the beat touches
	always_comb begin
		sel_ch = 3'd0;
		if (in_op == dda_pkg::OP_SVC_MRD || in_op == dda_pkg::OP_SVC_MWR) begin
			sel_ch = in_ch;
		end else if (in_port[7:4] == 4'h0) begin
			if (in_op == dda_pkg::OP_PORT_WR && in_port[3:0] == dda_pkg::REG_MODE) begin
				sel_ch = {1'b0, in_data[1:0]};
			end else begin
				sel_ch = {1'b0, in_port[2:1]};
			end
		end else if (in_port[7:5] == 3'b110) begin
			if (in_op == dda_pkg::OP_PORT_WR && in_port[4:1] == dda_pkg::REG_MODE) begin
				sel_ch = {1'b1, in_data[1:0]};
			end else begin
				sel_ch = {1'b1, in_port[3:2]};
			end
		end else if (in_port[7:4] == 4'h8) begin
			case (in_port[3:0])
				4'h1:    sel_ch = 3'd2;
				4'h2:    sel_ch = 3'd3;
				4'h3:    sel_ch = 3'd1;
				4'h9:    sel_ch = 3'd6;
				4'hA:    sel_ch = 3'd7;
				4'hB:    sel_ch = 3'd5;
				default: sel_ch = 3'd0;
			endcase
		end
	end

	dda_chan_mem u_mem (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (sel_ch),
		.rd_data (rec_mem),
		.wr_en   (exec_fire),
		.wr_addr (ch_q),
		.wr_data (nrec)
	);

	// a record never written back since reset reads as zero
	assign rec = vld_q[ch_q] ? rec_mem : '0;

	// execute stage
	logic        is_first, is_second, is_page, k;
	logic [3:0]  rsl;
	logic        ff_new;
	logic [7:0]  val;
	logic [7:0]  rdv;
	logic [2:0]  mbit;
	logic [3:0]  nib;
	logic        svc_wr, svc_word, refuse, tc_hit;
	logic [16:0] cnt_dec;
	logic [23:0] a_step;
	logic [7:0]  chbit;
	logic        page_map;
	logic [7:0]  bp;

	always_comb begin
		is_first  = (port_q[7:4] == 4'h0);
		is_second = (port_q[7:5] == 3'b110);
		is_page   = (port_q[7:4] == 4'h8);
		k         = is_second;
		rsl       = is_second ? port_q[4:1] : port_q[3:0];
		ff_new    = ~ff_q[k];
		val       = data_q[7:0];
		nrec      = rec;
		mask_d    = mask_q;
		tc_d      = tc_q;
		cmd_d     = cmd_q;
		ff_d      = ff_q;
		lw_we     = 1'b0;
		page_we   = 1'b0;
		res       = '0;
		rdv       = 8'd0;
		mbit      = {k, val[1:0]};
		nib       = 4'd0;
		svc_wr    = (op_q == dda_pkg::OP_SVC_MWR);
		svc_word  = ch_q[2];
		chbit     = 8'd1 << ch_q;
		cnt_dec   = rec.cur_cnt - 17'd1;
		tc_hit    = cnt_dec[16];
		refuse    = 1'b0;
		a_step    = rec.cur_addr;
		page_map  = 1'b0;
		bp        = at_mode_q ? val : {4'd0, val[3:0]};

		case (op_q)
			dda_pkg::OP_PORT_RD: begin
				if (is_first || is_second) begin
					if (!rsl[3]) begin
						ff_d[k] = ff_new;
						if (!rsl[0]) begin
							if (k) begin
								rdv = ff_new ? rec.cur_addr[8:1] : rec.cur_addr[16:9];
							end else begin
								rdv = ff_new ? rec.cur_addr[7:0] : rec.cur_addr[15:8];
							end
						end else begin
							rdv = ff_new ? rec.cur_cnt[7:0] : rec.cur_cnt[15:8];
						end
					end else if (rsl == dda_pkg::REG_CMD_STAT) begin
						if (k) begin
							rdv  = {4'd0, tc_q[7:4]};
							tc_d = {4'd0, tc_q[3:0]};
						end else begin
							rdv  = {4'd0, tc_q[3:0]};
							tc_d = {tc_q[7:4], 4'd0};
						end
					end else if (!k && rsl == dda_pkg::REG_MCLR) begin
						rdv = 8'd0;
					end else begin
						rdv = lw_q[k][rsl];
					end
				end else if (is_page) begin
					rdv = page_q[port_q[3:0]];
				end
				res[7:0] = rdv;
			end
			dda_pkg::OP_PORT_WR: begin
				if (is_first || is_second) begin
					lw_we = 1'b1;
					if (!rsl[3]) begin
						ff_d[k] = ff_new;
						if (!rsl[0]) begin
							if (k) begin
								if (ff_new) nrec.base_addr[8:1] = val;
								else        nrec.base_addr[16:9] = val;
							end else begin
								if (ff_new) nrec.base_addr[7:0] = val;
								else        nrec.base_addr[15:8] = val;
							end
							nrec.cur_addr = nrec.base_addr;
						end else begin
							if (ff_new) nrec.base_cnt[7:0] = val;
							else        nrec.base_cnt[15:8] = val;
							nrec.cur_cnt = {1'b0, nrec.base_cnt};
						end
					end else begin
						unique case (rsl)
							dda_pkg::REG_CMD_STAT: if (!k) cmd_d = val;
							dda_pkg::REG_SMASK:    mask_d[mbit] = val[2];
							dda_pkg::REG_MODE:     nrec.mode = val;
							dda_pkg::REG_CLR_FF:   ff_d[k] = 1'b0;
							dda_pkg::REG_MCLR: begin
								ff_d[k] = 1'b0;
								nib     = 4'hF;
								if (k) mask_d[7:4] = nib;
								else   mask_d[3:0] = nib;
							end
							dda_pkg::REG_CLR_MASK: begin
								if (k) mask_d[7:4] = nib;
								else   mask_d[3:0] = nib;
							end
							dda_pkg::REG_MASK_ALL: begin
								nib = val[3:0];
								if (k) mask_d[7:4] = nib;
								else   mask_d[3:0] = nib;
							end
							default: ;
						endcase
					end
				end else if (is_page) begin
					page_we = 1'b1;
					case (port_q[3:0])
						4'h1, 4'h2, 4'h3, 4'h7, 4'h9, 4'hA, 4'hB: page_map = 1'b1;
						default: page_map = 1'b0;
					endcase
					if (page_map) begin
						if (port_q[3]) begin
							nrec.base_addr[23:17] = val[7:1];
							nrec.cur_addr[23:17]  = val[7:1];
						end else begin
							nrec.base_addr[23:16] = bp;
							nrec.cur_addr[23:16]  = bp;
						end
					end
				end
			end
			default: begin
				// service beat
				refuse = (!svc_word && cmd_q[2]) || mask_q[ch_q] ||
					(rec.mode[3:2] != (svc_wr ? 2'b01 : 2'b10));
				if (refuse) begin
					res[51] = 1'b1;
				end else begin
					res[8]     = 1'b1;
					res[9]     = svc_wr;
					res[10]    = svc_word;
					res[34:11] = rec.cur_addr;
					if (svc_wr) begin
						res[50:35] = svc_word ? data_q : {8'd0, data_q[7:0]};
					end
					if (svc_word) begin
						a_step = rec.mode[5] ? rec.cur_addr - 24'd2 : rec.cur_addr + 24'd2;
						nrec.cur_addr = {rec.cur_addr[23:17], a_step[16:0]};
					end else begin
						a_step = rec.mode[5] ? rec.cur_addr - 24'd1 : rec.cur_addr + 24'd1;
						nrec.cur_addr = {rec.cur_addr[23:16], a_step[15:0]};
					end
					nrec.cur_cnt = cnt_dec;
					if (tc_hit) begin
						if (rec.mode[4]) begin
							nrec.cur_cnt  = {1'b0, rec.base_cnt};
							nrec.cur_addr = rec.base_addr;
						end else begin
							mask_d = mask_q | chbit;
						end
						tc_d = tc_q | chbit;
					end
					res[52] = svc_wr ? mask_d[ch_q] : tc_hit;
				end
			end
		endcase
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dda_pkg::ST_IDLE: if (accept) state_d = dda_pkg::ST_EXEC;
			dda_pkg::ST_EXEC: if (exec_fire) state_d = dda_pkg::ST_IDLE;
			default: state_d = dda_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dda_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= in_op;
			port_q <= in_port;
			data_q <= in_data;
			ch_q   <= sel_ch;
		end
		if (exec_fire) begin
			m_data_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_mode_q <= 1'b1;
			mask_q    <= '0;
			tc_q      <= '0;
			cmd_q     <= '0;
			ff_q      <= '0;
			vld_q     <= '0;
			m_valid_q <= 1'b0;
			for (int i = 0; i < 16; i++) begin
				lw_q[0][i] <= '0;
				lw_q[1][i] <= '0;
				page_q[i]  <= '0;
			end
		end else begin
			if (cfg_we) begin
				at_mode_q <= cfg_wdata;
			end
			if (exec_fire) begin
				mask_q      <= mask_d;
				tc_q        <= tc_d;
				cmd_q       <= cmd_d;
				ff_q        <= ff_d;
				vld_q[ch_q] <= 1'b1;
				m_valid_q   <= 1'b1;
				if (lw_we) begin
					lw_q[k][rsl] <= val;
				end
				if (page_we) begin
					page_q[port_q[3:0]] <= val;
				end
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

endmodule

### rtl/core/dda_checker.sv
// ----------------------------------------------------------------------------
// dda_checker
// port level checks for the dual at dma controller core
// ----------------------------------------------------------------------------
module dda_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [55:0] m_tdata
);

	// a beat is taken, then the block works on it before taking another
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken on consecutive cycles");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[8] && m_tdata[51]))
		else $error("transfer and refusal together");

	a_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[8] |-> m_tdata[50:9] == 42'd0 && !m_tdata[52])
		else $error("memory fields set without a transfer");

endmodule

bind dual_dma_controller_at_core dda_checker u_dda_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
